[rtl/core/canrx_pkg.sv]
// shared constants and widths for the can transport receive reassembler
package canrx_pkg;

  // field widths of the frame and result beats and the configuration port
  localparam int FRAME_W = 64;
  localparam int FLEN_W = 4;
  localparam int MSG_LEN_W = 9;
  localparam int CFG_W = 8;
  localparam int CFG_INDEX_W = 1;

  // default size of the message buffer in bytes
  localparam int DEFAULT_BUFFER_BYTES = 256;

  // protocol control info types and flow control status
  localparam logic [3:0] PCI_FIRST = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;
  localparam logic [7:0] FC_CLEAR_TO_SEND = 8'h30;
  localparam logic [3:0] FRAME_MAX_BYTES = 4'd8;

  // result kinds
  localparam logic KIND_FLOW_CONTROL = 1'b0;
  localparam logic KIND_MESSAGE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATION_TIME = 1'b1;

endpackage

[rtl/core/canrx_if.sv]
// valid/ready channel interfaces for received frames and results
interface canrx_frame_if;
  logic valid;
  logic ready;
  logic [canrx_pkg::FRAME_W-1:0] frame_bytes;
  logic [canrx_pkg::FLEN_W-1:0] frame_length;

  modport source (output valid, output frame_bytes, output frame_length, input ready);
  modport sink (input valid, input frame_bytes, input frame_length, output ready);
endinterface

interface canrx_result_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [canrx_pkg::FRAME_W-1:0] result_word;
  logic [canrx_pkg::FLEN_W-1:0] word_bytes;
  logic [canrx_pkg::MSG_LEN_W-1:0] message_length;
  logic last_word;

  modport source (output valid, output result_kind, output result_word, output word_bytes,
                  output message_length, output last_word, input ready);
  modport sink (input valid, input result_kind, input result_word, input word_bytes,
                input message_length, input last_word, output ready);
endinterface

[rtl/core/can_transport_rx_reassembler.sv]
// Receive-side CAN transport reassembler. One frame beat is taken at a time
// and its payload is written into a byte-wide message buffer, one byte per
// cycle through a single write port. A first frame is taken, its stored bytes
// are written, and then its clear-to-send flow control beat is posted once the
// output register is free. A consecutive frame is taken and its stored bytes
// are written. When the message completes, the buffer is read back through its
// one read port with a registered read, one byte per cycle within a result
// beat; each result beat of up to 8 bytes is loaded once its bytes are read
// and the output register is free. No frame is taken during that readout. A
// result beat waits in an output register, so the next frame can be taken
// while the flow control beat has not been accepted yet.
module can_transport_rx_reassembler #(
  parameter int BUFFER_BYTES = canrx_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic clk,
  input  logic rst,
  canrx_frame_if.sink frame,
  canrx_result_if.source result,
  input  logic cfg_write,
  input  logic [canrx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [canrx_pkg::CFG_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int FW = canrx_pkg::FRAME_W;

  // state codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_FLOW  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // control registers
  logic [1:0] state;
  logic [1:0] follow_state;
  logic [LEN_W-1:0] expected_length;
  logic [LEN_W-1:0] received_length;
  logic [3:0] next_sequence;
  logic receiving;
  logic [7:0] fc_block_size;
  logic [7:0] fc_separation_time;
  logic [LEN_W-1:0] wr_ptr;
  logic [3:0] wr_left;
  logic [LEN_W-1:0] pos;
  logic [3:0] issue_cnt;
  logic rd_valid;
  logic out_valid;

  // datapath registers
  logic [FW-1:0] wr_shift;
  logic [FW-1:0] acc;
  logic [2:0] rd_slot;
  logic [7:0] rd_data;
  logic out_kind;
  logic [FW-1:0] out_word;
  logic [canrx_pkg::FLEN_W-1:0] out_bytes;
  logic [canrx_pkg::MSG_LEN_W-1:0] out_mlen;
  logic out_last;

  // message buffer
  logic [7:0] mem [0:BUFFER_BYTES-1];

  // frame decode
  logic accept;
  logic [3:0] len_c;
  logic [3:0] pci_kind;
  logic [3:0] pci_nib;
  logic [11:0] announced;
  logic ff_ok;
  logic [3:0] ff_n;
  logic cf_take;
  logic seq_ok;
  logic [LEN_W-1:0] room;
  logic [3:0] cf_n;
  logic [LEN_W-1:0] cf_recv_next;
  logic cf_done;

  // readout control
  logic [LEN_W-1:0] remain;
  logic [3:0] word_n;
  logic [LEN_W-1:0] pos_next;
  logic issue;
  logic out_free;
  logic out_load;
  logic emit_load;
  logic emit_last;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W+canrx_pkg::MSG_LEN_W-1:0] mlen_ext;

  assign frame.ready = (state == S_IDLE);
  assign accept = frame.valid && frame.ready;
  assign out_free = !out_valid || result.ready;
  assign out_load = (state == S_FLOW && out_free) || emit_load;

  // frame header decode
  always_comb begin
    len_c = (frame.frame_length > canrx_pkg::FRAME_MAX_BYTES) ?
            canrx_pkg::FRAME_MAX_BYTES : frame.frame_length;
    pci_kind = frame.frame_bytes[63:60];
    pci_nib = frame.frame_bytes[59:56];
    announced = {pci_nib, frame.frame_bytes[55:48]};
    ff_ok = (pci_kind == canrx_pkg::PCI_FIRST) && (len_c >= 4'd2) &&
            (announced <= 12'(BUFFER_BYTES));
    ff_n = len_c - 4'd2;
    if ({8'b0, ff_n} > announced) begin
      ff_n = announced[3:0];
    end
    cf_take = (pci_kind == canrx_pkg::PCI_CONSECUTIVE) && receiving && (len_c != 4'd0);
    seq_ok = (pci_nib == next_sequence);
    room = (expected_length > received_length) ? (expected_length - received_length) :
           {LEN_W{1'b0}};
    cf_n = (len_c == 4'd0) ? 4'd0 : (len_c - 4'd1);
    if (LEN_W'(cf_n) > room) begin
      cf_n = room[3:0];
    end
    cf_recv_next = received_length + LEN_W'(cf_n);
    cf_done = (cf_recv_next >= expected_length);
  end

  // readout word sizing
  always_comb begin
    remain = expected_length - pos;
    word_n = (remain > LEN_W'(canrx_pkg::FRAME_MAX_BYTES)) ? canrx_pkg::FRAME_MAX_BYTES :
             remain[3:0];
    pos_next = pos + LEN_W'(word_n);
    emit_last = (pos_next >= expected_length);
    issue = (state == S_EMIT) && (issue_cnt < word_n);
    emit_load = (state == S_EMIT) && (issue_cnt == word_n) && !rd_valid && out_free;
    rd_addr = ADDR_W'(pos + LEN_W'(issue_cnt));
    mlen_ext = {{canrx_pkg::MSG_LEN_W{1'b0}}, expected_length};
  end

  // buffer write and registered read
  always_ff @(posedge clk) begin
    if (state == S_WRITE && wr_left != 4'd0) begin
      mem[wr_ptr[ADDR_W-1:0]] <= wr_shift[FW-1 -: 8];
    end
    rd_data <= mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fc_block_size <= '0;
      fc_separation_time <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        canrx_pkg::CFG_BLOCK_SIZE: fc_block_size <= cfg_data;
        canrx_pkg::CFG_SEPARATION_TIME: fc_separation_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      follow_state <= S_IDLE;
      expected_length <= '0;
      received_length <= '0;
      next_sequence <= 4'd1;
      receiving <= 1'b0;
      wr_ptr <= '0;
      wr_left <= '0;
      pos <= '0;
      issue_cnt <= '0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && len_c != 4'd0) begin
            if (ff_ok) begin
              expected_length <= LEN_W'(announced);
              received_length <= LEN_W'(ff_n);
              next_sequence <= 4'd1;
              receiving <= 1'b1;
              wr_ptr <= '0;
              wr_left <= ff_n;
              follow_state <= S_FLOW;
              state <= S_WRITE;
            end else if (cf_take) begin
              if (seq_ok) begin
                received_length <= cf_recv_next;
                next_sequence <= next_sequence + 4'd1;
                wr_ptr <= received_length;
                wr_left <= cf_n;
                pos <= '0;
                issue_cnt <= '0;
                if (cf_done) begin
                  receiving <= 1'b0;
                  follow_state <= S_EMIT;
                end else begin
                  follow_state <= S_IDLE;
                end
                state <= S_WRITE;
              end else begin
                receiving <= 1'b0;
              end
            end
          end
        end
        S_WRITE: begin
          if (wr_left != 4'd0) begin
            wr_left <= wr_left - 4'd1;
            wr_ptr <= wr_ptr + LEN_W'(1);
          end else begin
            state <= follow_state;
          end
        end
        S_FLOW: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (issue) begin
            issue_cnt <= issue_cnt + 4'd1;
          end
          if (emit_load) begin
            pos <= pos_next;
            issue_cnt <= '0;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload shifting, word assembly and output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_shift <= ff_ok ? {frame.frame_bytes[FW-17:0], 16'b0} :
                  {frame.frame_bytes[FW-9:0], 8'b0};
    end else if (state == S_WRITE) begin
      wr_shift <= {wr_shift[FW-9:0], 8'b0};
    end
    rd_slot <= issue_cnt[2:0];
    if (state != S_EMIT || emit_load) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc[{3'd7 - rd_slot, 3'b000} +: 8] <= rd_data;
    end
    if (state == S_FLOW && out_free) begin
      out_kind <= canrx_pkg::KIND_FLOW_CONTROL;
      out_word <= {canrx_pkg::FC_CLEAR_TO_SEND, fc_block_size, fc_separation_time,
                   {(FW-24){1'b0}}};
      out_bytes <= canrx_pkg::FRAME_MAX_BYTES;
      out_mlen <= '0;
      out_last <= 1'b1;
    end else if (emit_load) begin
      out_kind <= canrx_pkg::KIND_MESSAGE;
      out_word <= acc;
      out_bytes <= word_n;
      out_mlen <= mlen_ext[canrx_pkg::MSG_LEN_W-1:0];
      out_last <= emit_last;
    end
  end

  // result channel
  assign result.valid = out_valid;
  assign result.result_kind = out_kind;
  assign result.result_word = out_word;
  assign result.word_bytes = out_bytes;
  assign result.message_length = out_mlen;
  assign result.last_word = out_last;

endmodule
